FILE: rtl/va_pkg.sv
// Shared types, constants and rounding helpers for the four-component vector unit.
// Used by every module in rtl/; depends on nothing else.
package va_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int WORD_W     = 32;
  localparam int PROD_W     = 2 * WORD_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int AS_W       = WORD_W + 1;
  localparam int RAD_W      = PROD_W;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int REM_W      = ROOT_W + 2;
  localparam int SQ_STAGES  = ROOT_W;
  localparam int NUM_W      = WORD_W + FRAC_BITS;
  localparam int DIV_STAGES = NUM_W;
  localparam int MINLEN_W   = 16;
  localparam int N_MUL      = 6;
  localparam int FRONT_STAGES = 4;
  localparam int LATENCY    = FRONT_STAGES + SQ_STAGES + 1 + DIV_STAGES + 1;

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  typedef enum logic [2:0] {
    CMD_ADD   = 3'd0,
    CMD_SUB   = 3'd1,
    CMD_SCALE = 3'd2,
    CMD_MUL   = 3'd3,
    CMD_DOT   = 3'd4,
    CMD_CROSS = 3'd5,
    CMD_LEN   = 3'd6,
    CMD_NORM  = 3'd7
  } cmd_t;

  typedef logic [3:0][WORD_W-1:0] vec_t;
  typedef logic [3:0][NUM_W-1:0]  numvec_t;

  // Item context carried alongside the square root pipeline.
  typedef struct packed {
    cmd_t cmd;
    vec_t r;
    logic sat;
    vec_t a;
  } side_t;

  // Item context carried alongside the divider pipeline.
  typedef struct packed {
    cmd_t       cmd;
    vec_t       r;
    logic       sat;
    logic       ok;
    logic [3:0] neg;
  } dside_t;

  // Clamp a wide signed value to one word; the top bit of the result is the clamp flag.
  function automatic logic [WORD_W:0] sat_word(input logic signed [ACC_W-1:0] v);
    logic ovf;
    ovf = (v[ACC_W-1:WORD_W-1] != {(ACC_W-WORD_W+1){v[WORD_W-1]}});
    if (ovf) begin
      return {1'b1, (v[ACC_W-1] ? WORD_MIN : WORD_MAX)};
    end
    return {1'b0, v[WORD_W-1:0]};
  endfunction

  // Round to nearest with ties toward plus infinity, drop the fraction, then clamp.
  function automatic logic [WORD_W:0] round_sat(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    t = (v + RND_HALF) >>> FRAC_BITS;
    return sat_word(t);
  endfunction

endpackage

FILE: rtl/va_front.sv
// Front end of the vector unit: operand select, multipliers, sums and rounding.
// Four register stages; depends on va_pkg.
module va_front
  import va_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  cmd_t                 in_cmd,
  input  vec_t                 in_a,
  input  vec_t                 in_b,
  input  logic [WORD_W-1:0]    in_s,
  output logic                 out_vld,
  output side_t                out_side,
  output logic [RAD_W-1:0]     out_sumsq
);

  // Stage 1: input registers.
  logic              v1_r;
  cmd_t              cmd1_r;
  vec_t              a1_r, b1_r;
  logic [WORD_W-1:0] s1_r;

  // Stage 2: products and add/sub.
  logic signed [WORD_W-1:0] opx [N_MUL];
  logic signed [WORD_W-1:0] opy [N_MUL];
  logic signed [PROD_W-1:0] p_nxt [N_MUL];
  logic signed [AS_W-1:0]   as_nxt [4];
  logic                     v2_r;
  cmd_t                     cmd2_r;
  vec_t                     a2_r;
  logic signed [PROD_W-1:0] p2_r [N_MUL];
  logic signed [AS_W-1:0]   as2_r [4];

  // Stage 3: exact sums.
  logic signed [ACC_W-1:0] pe [N_MUL];
  logic signed [ACC_W-1:0] w_nxt [4];
  logic [RAD_W-1:0]        sq_nxt;
  logic                    v3_r;
  cmd_t                    cmd3_r;
  vec_t                    a3_r;
  logic signed [ACC_W-1:0] w3_r [4];
  logic [RAD_W-1:0]        sq3_r;

  // Stage 4: rounding and clamping.
  side_t              side_nxt;
  logic [WORD_W:0]    rs [4];
  logic               v4_r;
  side_t              side4_r;
  logic [RAD_W-1:0]   sq4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    cmd1_r <= in_cmd;
    a1_r   <= in_a;
    b1_r   <= in_b;
    s1_r   <= in_s;
  end

  always_comb begin
    for (int i = 0; i < N_MUL; i++) begin
      opx[i] = '0;
      opy[i] = '0;
    end
    unique case (cmd1_r)
      CMD_SCALE: begin
        for (int i = 0; i < 4; i++) begin
          opx[i] = a1_r[i];
          opy[i] = s1_r;
        end
      end
      CMD_CROSS: begin
        opx[0] = a1_r[1]; opy[0] = b1_r[2];
        opx[1] = a1_r[2]; opy[1] = b1_r[1];
        opx[2] = a1_r[2]; opy[2] = b1_r[0];
        opx[3] = a1_r[0]; opy[3] = b1_r[2];
        opx[4] = a1_r[0]; opy[4] = b1_r[1];
        opx[5] = a1_r[1]; opy[5] = b1_r[0];
      end
      CMD_LEN, CMD_NORM: begin
        for (int i = 0; i < 3; i++) begin
          opx[i] = a1_r[i];
          opy[i] = a1_r[i];
        end
      end
      default: begin
        for (int i = 0; i < 4; i++) begin
          opx[i] = a1_r[i];
          opy[i] = b1_r[i];
        end
      end
    endcase
    for (int i = 0; i < N_MUL; i++) begin
      p_nxt[i] = opx[i] * opy[i];
    end
    for (int i = 0; i < 4; i++) begin
      if (cmd1_r == CMD_SUB) begin
        as_nxt[i] = $signed({a1_r[i][WORD_W-1], a1_r[i]}) -
                    $signed({b1_r[i][WORD_W-1], b1_r[i]});
      end else begin
        as_nxt[i] = $signed({a1_r[i][WORD_W-1], a1_r[i]}) +
                    $signed({b1_r[i][WORD_W-1], b1_r[i]});
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd2_r <= cmd1_r;
    a2_r   <= a1_r;
    for (int i = 0; i < N_MUL; i++) begin
      p2_r[i] <= p_nxt[i];
    end
    for (int i = 0; i < 4; i++) begin
      as2_r[i] <= as_nxt[i];
    end
  end

  // Add and sub results are placed at the product scale so the shared rounding is exact.
  always_comb begin
    for (int i = 0; i < N_MUL; i++) begin
      pe[i] = $signed({{(ACC_W-PROD_W){p2_r[i][PROD_W-1]}}, p2_r[i]});
    end
    for (int i = 0; i < 4; i++) begin
      w_nxt[i] = '0;
    end
    unique case (cmd2_r)
      CMD_ADD, CMD_SUB: begin
        for (int i = 0; i < 4; i++) begin
          w_nxt[i] = $signed({{(ACC_W-AS_W-FRAC_BITS){as2_r[i][AS_W-1]}},
                              as2_r[i], {FRAC_BITS{1'b0}}});
        end
      end
      CMD_SCALE, CMD_MUL: begin
        for (int i = 0; i < 4; i++) begin
          w_nxt[i] = pe[i];
        end
      end
      CMD_DOT: begin
        w_nxt[0] = pe[0] + pe[1] + pe[2] + pe[3];
      end
      CMD_CROSS: begin
        w_nxt[0] = pe[0] - pe[1];
        w_nxt[1] = pe[2] - pe[3];
        w_nxt[2] = pe[4] - pe[5];
      end
      default: begin
        for (int i = 0; i < 4; i++) begin
          w_nxt[i] = '0;
        end
      end
    endcase
    sq_nxt = p2_r[0][RAD_W-1:0] + p2_r[1][RAD_W-1:0] + p2_r[2][RAD_W-1:0];
  end

  always_ff @(posedge clk) begin
    cmd3_r <= cmd2_r;
    a3_r   <= a2_r;
    sq3_r  <= sq_nxt;
    for (int i = 0; i < 4; i++) begin
      w3_r[i] <= w_nxt[i];
    end
  end

  always_comb begin
    side_nxt.cmd = cmd3_r;
    side_nxt.a   = a3_r;
    side_nxt.sat = 1'b0;
    for (int i = 0; i < 4; i++) begin
      rs[i] = round_sat(w3_r[i]);
      side_nxt.r[i] = rs[i][WORD_W-1:0];
      side_nxt.sat = side_nxt.sat | rs[i][WORD_W];
    end
  end

  always_ff @(posedge clk) begin
    side4_r <= side_nxt;
    sq4_r   <= sq3_r;
  end

  assign out_vld   = v4_r;
  assign out_side  = side4_r;
  assign out_sumsq = sq4_r;

endmodule

FILE: rtl/va_isqrt.sv
// Pipelined integer square root, one result bit per stage, with item context alongside.
// Depends on va_pkg.
module va_isqrt
  import va_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  side_t             in_side,
  input  logic [RAD_W-1:0]  in_rad,
  output logic              out_vld,
  output side_t             out_side,
  output logic [ROOT_W-1:0] out_root
);

  logic              vld_r  [SQ_STAGES];
  side_t             side_r [SQ_STAGES];
  logic [RAD_W-1:0]  rad_r  [SQ_STAGES];
  logic [REM_W-1:0]  rem_r  [SQ_STAGES];
  logic [ROOT_W-1:0] root_r [SQ_STAGES];

  logic              vld_i  [SQ_STAGES];
  side_t             side_i [SQ_STAGES];
  logic [RAD_W-1:0]  rad_i  [SQ_STAGES];
  logic [REM_W-1:0]  rem_i  [SQ_STAGES];
  logic [ROOT_W-1:0] root_i [SQ_STAGES];

  logic [REM_W+1:0]  cur    [SQ_STAGES];
  logic [REM_W+1:0]  trial  [SQ_STAGES];
  logic              ge     [SQ_STAGES];

  always_comb begin
    vld_i[0]  = in_vld;
    side_i[0] = in_side;
    rad_i[0]  = in_rad;
    rem_i[0]  = '0;
    root_i[0] = '0;
    for (int k = 1; k < SQ_STAGES; k++) begin
      vld_i[k]  = vld_r[k-1];
      side_i[k] = side_r[k-1];
      rad_i[k]  = rad_r[k-1];
      rem_i[k]  = rem_r[k-1];
      root_i[k] = root_r[k-1];
    end
    for (int k = 0; k < SQ_STAGES; k++) begin
      cur[k]   = {rem_i[k], rad_i[k][RAD_W-1 -: 2]};
      trial[k] = {2'b00, root_i[k], 2'b01};
      ge[k]    = (cur[k] >= trial[k]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < SQ_STAGES; k++) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_i[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < SQ_STAGES; k++) begin
      side_r[k] <= side_i[k];
      rad_r[k]  <= rad_i[k] << 2;
      rem_r[k]  <= ge[k] ? REM_W'(cur[k] - trial[k]) : cur[k][REM_W-1:0];
      root_r[k] <= {root_i[k][ROOT_W-2:0], ge[k]};
    end
  end

  assign out_vld  = vld_r[SQ_STAGES-1];
  assign out_side = side_r[SQ_STAGES-1];
  assign out_root = root_r[SQ_STAGES-1];

endmodule

FILE: rtl/va_div.sv
// Pipelined four-lane restoring divider by a shared divisor, one quotient bit per stage.
// Depends on va_pkg.
module va_div
  import va_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  dside_t            in_side,
  input  logic [ROOT_W-1:0] in_den,
  input  numvec_t           in_num,
  output logic              out_vld,
  output dside_t            out_side,
  output numvec_t           out_quo
);

  typedef logic [3:0][ROOT_W-1:0] remvec_t;

  logic              vld_r  [DIV_STAGES];
  dside_t            side_r [DIV_STAGES];
  logic [ROOT_W-1:0] den_r  [DIV_STAGES];
  remvec_t           rem_r  [DIV_STAGES];
  numvec_t           nq_r   [DIV_STAGES];

  logic              vld_i  [DIV_STAGES];
  dside_t            side_i [DIV_STAGES];
  logic [ROOT_W-1:0] den_i  [DIV_STAGES];
  remvec_t           rem_i  [DIV_STAGES];
  numvec_t           nq_i   [DIV_STAGES];

  remvec_t           rem_nxt [DIV_STAGES];
  numvec_t           nq_nxt  [DIV_STAGES];
  logic [ROOT_W:0]   t;
  logic              ge;

  always_comb begin
    vld_i[0]  = in_vld;
    side_i[0] = in_side;
    den_i[0]  = in_den;
    rem_i[0]  = '0;
    nq_i[0]   = in_num;
    for (int k = 1; k < DIV_STAGES; k++) begin
      vld_i[k]  = vld_r[k-1];
      side_i[k] = side_r[k-1];
      den_i[k]  = den_r[k-1];
      rem_i[k]  = rem_r[k-1];
      nq_i[k]   = nq_r[k-1];
    end
    t  = '0;
    ge = 1'b0;
    for (int k = 0; k < DIV_STAGES; k++) begin
      for (int j = 0; j < 4; j++) begin
        t  = {rem_i[k][j], nq_i[k][j][NUM_W-1]};
        ge = (t >= {1'b0, den_i[k]});
        rem_nxt[k][j] = ge ? ROOT_W'(t - {1'b0, den_i[k]}) : t[ROOT_W-1:0];
        nq_nxt[k][j]  = {nq_i[k][j][NUM_W-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_i[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      side_r[k] <= side_i[k];
      den_r[k]  <= den_i[k];
      rem_r[k]  <= rem_nxt[k];
      nq_r[k]   <= nq_nxt[k];
    end
  end

  assign out_vld  = vld_r[DIV_STAGES-1];
  assign out_side = side_r[DIV_STAGES-1];
  assign out_quo  = nq_r[DIV_STAGES-1];

endmodule

FILE: rtl/vector4_alu_unit.sv
// Top level of the four-component Q16.16 vector unit.
// Depends on va_pkg, va_front, va_isqrt and va_div.
//
// The unit takes one command per clock: a transfer happens at every rising edge with
// start high, and busy is always low because nothing inside can stall. Every command
// runs through the same fixed pipeline of LATENCY register stages: four stages of
// operand select, multiply, exact sum and rounding, 32 stages of the bit-per-stage
// square root, one stage that forms the normalize dividends, 48 stages of the
// four-lane bit-per-stage divider, and the output register.
// The sqrt and divider depths set the latency; throughput is one result per cycle.
// Each result appears on the out_ ports for exactly one cycle with out_valid high, in
// the order the commands were accepted, and the receiver must take it then. Scalar
// results (dot, length) are in out_r_x with the other components zero. min_length is
// written through the cfg_ port, which is always ready; write it only while no command
// is in flight.
module vector4_alu_unit
  import va_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [2:0]                 in_command,
  input  logic signed [WORD_W-1:0]   in_a_x,
  input  logic signed [WORD_W-1:0]   in_a_y,
  input  logic signed [WORD_W-1:0]   in_a_z,
  input  logic signed [WORD_W-1:0]   in_a_w,
  input  logic signed [WORD_W-1:0]   in_b_x,
  input  logic signed [WORD_W-1:0]   in_b_y,
  input  logic signed [WORD_W-1:0]   in_b_z,
  input  logic signed [WORD_W-1:0]   in_b_w,
  input  logic signed [WORD_W-1:0]   in_scale_factor,
  output logic                       out_valid,
  output logic signed [WORD_W-1:0]   out_r_x,
  output logic signed [WORD_W-1:0]   out_r_y,
  output logic signed [WORD_W-1:0]   out_r_z,
  output logic signed [WORD_W-1:0]   out_r_w,
  output logic                       out_saturated,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [MINLEN_W-1:0]        cfg_data
);

  logic [MINLEN_W-1:0] min_length_r;

  logic              fr_vld;
  side_t             fr_side;
  logic [RAD_W-1:0]  fr_sumsq;
  logic              sq_vld;
  side_t             sq_side;
  logic [ROOT_W-1:0] sq_root;

  dside_t            n_side_nxt;
  numvec_t           n_num_nxt;
  logic [WORD_W-1:0] mag;
  logic              n_vld_r;
  dside_t            n_side_r;
  logic [ROOT_W-1:0] n_den_r;
  numvec_t           n_num_r;

  logic              dv_vld;
  dside_t            dv_side;
  numvec_t           dv_quo;

  vec_t              o_r_nxt;
  logic              o_sat_nxt;
  logic              o_big, o_ovf;
  logic              out_valid_r;
  vec_t              out_r_r;
  logic              out_sat_r;
  cmd_t              out_cmd_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_length_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      min_length_r <= cfg_data;
    end
  end

  va_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (start && !busy),
    .in_cmd    (cmd_t'(in_command)),
    .in_a      ({in_a_w, in_a_z, in_a_y, in_a_x}),
    .in_b      ({in_b_w, in_b_z, in_b_y, in_b_x}),
    .in_s      (in_scale_factor),
    .out_vld   (fr_vld),
    .out_side  (fr_side),
    .out_sumsq (fr_sumsq)
  );

  va_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (fr_vld),
    .in_side  (fr_side),
    .in_rad   (fr_sumsq),
    .out_vld  (sq_vld),
    .out_side (sq_side),
    .out_root (sq_root)
  );

  // Dividend stage: rounded division of |a| scaled up by the fraction bits, by the length.
  // The length result itself is also clamped here, since it is known from this point on.
  always_comb begin
    n_side_nxt.cmd = sq_side.cmd;
    n_side_nxt.r   = sq_side.r;
    n_side_nxt.sat = sq_side.sat;
    n_side_nxt.ok  = (sq_root > {{(ROOT_W-MINLEN_W){1'b0}}, min_length_r});
    mag = '0;
    for (int j = 0; j < 4; j++) begin
      n_side_nxt.neg[j] = sq_side.a[j][WORD_W-1];
      mag = n_side_nxt.neg[j] ? WORD_W'(-sq_side.a[j]) : sq_side.a[j];
      n_num_nxt[j] = (NUM_W'(mag) << FRAC_BITS) + NUM_W'(sq_root >> 1);
    end
    if (sq_side.cmd == CMD_LEN) begin
      n_side_nxt.r[0] = sq_root[ROOT_W-1] ? WORD_MAX : WORD_W'(sq_root);
      n_side_nxt.sat  = sq_root[ROOT_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_vld_r <= 1'b0;
    end else begin
      n_vld_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    n_side_r <= n_side_nxt;
    n_den_r  <= sq_root;
    n_num_r  <= n_num_nxt;
  end

  va_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (n_vld_r),
    .in_side  (n_side_r),
    .in_den   (n_den_r),
    .in_num   (n_num_r),
    .out_vld  (dv_vld),
    .out_side (dv_side),
    .out_quo  (dv_quo)
  );

  // Final select. A normalize quotient is applied with its sign and clamped (zero when not ok);
  // a negative quotient of exactly the most negative magnitude still fits.
  always_comb begin
    o_r_nxt   = dv_side.r;
    o_sat_nxt = dv_side.sat;
    o_big     = 1'b0;
    o_ovf     = 1'b0;
    if (dv_side.cmd == CMD_NORM) begin
      o_sat_nxt = 1'b0;
      for (int j = 0; j < 4; j++) begin
        o_r_nxt[j] = '0;
        o_big = |dv_quo[j][NUM_W-1:WORD_W];
        if (dv_side.neg[j]) begin
          o_ovf = o_big || (dv_quo[j][WORD_W-1] && |dv_quo[j][WORD_W-2:0]);
        end else begin
          o_ovf = o_big || dv_quo[j][WORD_W-1];
        end
        if (dv_side.ok) begin
          if (o_ovf) begin
            o_r_nxt[j] = dv_side.neg[j] ? WORD_MIN : WORD_MAX;
          end else if (dv_side.neg[j]) begin
            o_r_nxt[j] = WORD_W'(-dv_quo[j][WORD_W-1:0]);
          end else begin
            o_r_nxt[j] = dv_quo[j][WORD_W-1:0];
          end
          o_sat_nxt = o_sat_nxt | o_ovf;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_r_r   <= o_r_nxt;
    out_sat_r <= o_sat_nxt;
    out_cmd_r <= dv_side.cmd;
  end

  assign out_valid     = out_valid_r;
  assign out_r_x       = out_r_r[0];
  assign out_r_y       = out_r_r[1];
  assign out_r_z       = out_r_r[2];
  assign out_r_w       = out_r_r[3];
  assign out_saturated = out_sat_r;

  // Every accepted command yields its result with out_valid high, and no
  // result appears without a command behind it.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("accepted command produced no result at the expected cycle");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result strobe without a matching accepted command");

  a_scalar_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_cmd_r == CMD_DOT || out_cmd_r == CMD_LEN)) |->
      (out_r_y == '0 && out_r_z == '0 && out_r_w == '0))
    else $error("scalar result with nonzero upper components");

  a_cross_w: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_cmd_r == CMD_CROSS) |-> (out_r_w == '0))
    else $error("cross product with nonzero w");

  a_len_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_cmd_r == CMD_LEN) |-> !out_r_x[WORD_W-1])
    else $error("negative length");

endmodule
